>>> rtl/core/pwrt_pkg.sv
`timescale 1ns / 1ps

package pwrt_pkg;

    localparam int DEPTH = 256;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SKIP  = 2'd1,
        ST_ORDER = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RA_LAST,
        RA_MID,
        RA_LO
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    step;
        logic    commit;
    } pwrt_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic cnt_zero;
        logic more;
    } pwrt_stat_t;

endpackage

>>> rtl/core/pwrt_ctrl.sv
`timescale 1ns / 1ps

module pwrt_ctrl
    import pwrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  pwrt_stat_t stat,
    output pwrt_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (stat.cnt_zero)
                    state_next = S_DONE;
                else if (stat.is_lookup && stat.more)
                    state_next = S_SEARCH;
                else
                    state_next = S_WAIT;
            end
            S_SEARCH:
            begin
                if (!stat.more)
                    state_next = S_WAIT;
            end
            S_WAIT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RA_LAST;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_DISPATCH:
            begin
                if (!stat.cnt_zero)
                begin
                    cmd.rd_en = 1'b1;
                    if (!stat.is_lookup)
                        cmd.rd_sel = RA_LAST;
                    else if (stat.more)
                        cmd.rd_sel = RA_MID;
                    else
                        cmd.rd_sel = RA_LO;
                end
            end
            S_SEARCH:
            begin
                cmd.step   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stat.more ? RA_MID : RA_LO;
            end
            S_WAIT:
                cmd.rd_en = 1'b0;
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // a new result only appears from the final state
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside final state");

endmodule

>>> rtl/core/pwrt_dp.sv
`timescale 1ns / 1ps

module pwrt_dp
    import pwrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operation,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  pwrt_cmd_t   cmd,
    output pwrt_stat_t  stat,
    output logic [31:0] mapped,
    output logic [1:0]  status
);

    logic [WIDTH-1:0] key_mem [DEPTH];
    logic [WIDTH-1:0] val_mem [DEPTH];

    logic             op_reg;
    logic [WIDTH-1:0] key_reg;
    logic [WIDTH-1:0] val_reg;
    logic [IDX_W-1:0] lo_reg;
    logic [IDX_W-1:0] hi_reg;
    logic [IDX_W-1:0] mid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [WIDTH-1:0] rd_key_reg;
    logic [WIDTH-1:0] rd_val_reg;
    logic [31:0]      mapped_reg;
    status_t          status_reg;

    logic [IDX_W-1:0] lo_next;
    logic [IDX_W-1:0] hi_next;
    logic [CNT_W-1:0] span;
    logic [IDX_W-1:0] mid_next;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] rd_addr;
    logic             cnt_zero;
    logic             cnt_full;
    status_t          app_status;
    logic [WIDTH-1:0] lookup_res;
    logic             wr_en;

    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == CNT_W'(DEPTH));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // narrow the search window on the word just read at mid
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.step)
        begin
            if (key_reg < rd_key_reg)
                hi_next = mid_reg - IDX_W'(1);
            else
                lo_next = mid_reg;
        end
    end

    assign span     = {1'b0, hi_next} - {1'b0, lo_next} + CNT_W'(1);
    assign mid_next = lo_next + span[CNT_W-1:1];

    always_comb
    begin
        case (cmd.rd_sel)
            RA_LAST: rd_addr = last_idx;
            RA_MID:  rd_addr = mid_next;
            RA_LO:   rd_addr = lo_next;
            default: rd_addr = lo_next;
        endcase
    end

    always_comb
    begin
        if (cnt_zero)
            app_status = (key_reg == val_reg) ? ST_SKIP : ST_OK;
        else if (key_reg <= rd_key_reg)
            app_status = ST_ORDER;
        else if ((val_reg - key_reg) == (rd_val_reg - rd_key_reg))
            app_status = ST_SKIP;
        else if (cnt_full)
            app_status = ST_FULL;
        else
            app_status = ST_OK;
    end

    // below the first breakpoint only when the search settled on entry zero
    assign lookup_res = (cnt_zero || key_reg < rd_key_reg) ? key_reg
                                                            : key_reg - rd_key_reg + rd_val_reg;

    assign wr_en = cmd.commit && (op_reg == OP_APPEND) && (app_status == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (wr_en)
            count_reg <= count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            key_reg <= key;
            val_reg <= value;
            lo_reg  <= '0;
            hi_reg  <= last_idx;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (cmd.rd_en && cmd.rd_sel == RA_MID)
            mid_reg <= mid_next;
        if (cmd.commit)
        begin
            mapped_reg <= (op_reg == OP_LOOKUP) ? lookup_res : '0;
            status_reg <= (op_reg == OP_LOOKUP) ? ST_OK : app_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[count_reg[IDX_W-1:0]] <= key_reg;
            val_mem[count_reg[IDX_W-1:0]] <= val_reg;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    assign stat.is_lookup = (op_reg == OP_LOOKUP);
    assign stat.cnt_zero  = cnt_zero;
    assign stat.more      = (lo_next < hi_next);

    assign mapped = mapped_reg;
    assign status = status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_store_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !cnt_full)
        else $error("store into a full table");

    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lo_reg < hi_reg))
        else $error("search step on a closed window");

endmodule

>>> rtl/core/piecewise_offset_remap_table.sv
`timescale 1ns / 1ps
// An append makes one registered read of the last breakpoint before its result (none on an empty table);
// a lookup over n entries binary-searches the breakpoint memory (no read on an empty
// table), with one registered read of the breakpoint memory per search step.
// Throughput: one item at a time; the next item is accepted the cycle after the result loads.
// Reset (rst_n, async, active low) empties the table and drops any pending result.

module piecewise_offset_remap_table
    import pwrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] mapped,
    output logic [1:0]  status
);

    pwrt_cmd_t  cmd;
    pwrt_stat_t stat;

    pwrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pwrt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .key       (key),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .mapped    (mapped),
        .status    (status)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import pwrt_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          TAIL_CYCLES  = 20;

    typedef struct {
        logic [31:0] mapped;
        status_t     status;
    } remap_result_t;

    // Scoreboard: tracks the breakpoint table and the results still owed by the block.
    class remap_scoreboard;
        logic [WIDTH-1:0] bp_key [DEPTH];
        logic [WIDTH-1:0] bp_val [DEPTH];
        int unsigned      n_entries;
        remap_result_t    pending_remaps[$];
        int               errors;
        int               lookups;
        int               results_seen;
        int               append_status[4];

        function new();
            n_entries    = 0;
            errors       = 0;
            lookups      = 0;
            results_seen = 0;
            foreach (append_status[i]) append_status[i] = 0;
        endfunction

        function status_t append_pair(logic [WIDTH-1:0] k, logic [WIDTH-1:0] v);
            logic [WIDTH-1:0] last_key;
            logic [WIDTH-1:0] last_delta;
            logic [WIDTH-1:0] new_delta;
            if (n_entries == 0)
            begin
                if (k == v)
                    return ST_SKIP;
            end
            else
            begin
                last_key   = bp_key[n_entries - 1];
                last_delta = bp_val[n_entries - 1] - last_key;
                new_delta  = v - k;
                if (k <= last_key)
                    return ST_ORDER;
                if (new_delta == last_delta)
                    return ST_SKIP;
            end
            if (n_entries >= DEPTH)
                return ST_FULL;
            bp_key[n_entries] = k;
            bp_val[n_entries] = v;
            n_entries++;
            return ST_OK;
        endfunction

        function logic [WIDTH-1:0] translate_offset(logic [WIDTH-1:0] k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            if (n_entries == 0 || k < bp_key[0])
                return k;
            lo = 0;
            hi = n_entries - 1;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (k < bp_key[mid])
                    hi = mid - 1;
                else
                    lo = mid;
            end
            return k - bp_key[lo] + bp_val[lo];
        endfunction

        function void note_item(logic op, logic [31:0] k, logic [31:0] v);
            remap_result_t r;
            if (op == OP_APPEND)
            begin
                r.mapped = '0;
                r.status = append_pair(k, v);
                append_status[r.status]++;
            end
            else
            begin
                r.mapped = translate_offset(k);
                r.status = ST_OK;
                lookups++;
            end
            pending_remaps = {pending_remaps, r};
        endfunction

        function void check_result(logic [31:0] m, logic [1:0] s);
            remap_result_t r;
            results_seen++;
            if (pending_remaps.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, mapped %h status %0d",
                         $time, m, s);
                errors++;
                return;
            end
            r = pending_remaps.pop_front();
            if (m !== r.mapped)
            begin
                $display("%0t: mapped mismatch, expected %h, actual %h", $time, r.mapped, m);
                errors++;
            end
            if (s !== r.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, r.status, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] mapped;
    logic [1:0]  status;

    remap_scoreboard sb;
    int unsigned     cycle_count = 0;
    int              burst_left;
    int              stall_run = 0;
    int              free_run = 0;

    piecewise_offset_remap_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mapped    (mapped),
        .status    (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver side: short stalls, occasional long ones, and quiet stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else if (free_run > 0)
        begin
            out_stall <= 1'b0;
            free_run--;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       free_run  = $urandom_range(30, 200);
                1:       stall_run = $urandom_range(15, 40);
                2, 3, 4: stall_run = $urandom_range(1, 3);
                default: free_run  = $urandom_range(0, 4);
            endcase
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(mapped, status);
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(logic op, logic [31:0] k, logic [31:0] v, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        do @(posedge clk); while (in_stall);
        sb.note_item(op, k, v);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_remaps.size() != 0);
    endtask

    function automatic logic [31:0] next_key_above(logic [31:0] last_key);
        logic [31:0] room;
        logic [31:0] step;
        room = 32'hFFFF_FFFF - last_key;
        step = ($urandom_range(0, 9) == 0) ? 32'd1 : $urandom_range(1, 32'h00C0_0000);
        if (room == 0)
            return last_key;
        if (step > room)
            step = room;
        return last_key + step;
    endfunction

    task automatic send_random_append();
        logic [31:0] last_key;
        logic [31:0] last_delta;
        logic [31:0] k;
        logic [31:0] v;
        int          r;
        r = $urandom_range(0, 99);
        if (sb.n_entries == 0)
        begin
            k = $urandom();
            v = (r < 20) ? k : $urandom();
        end
        else
        begin
            last_key   = sb.bp_key[sb.n_entries - 1];
            last_delta = sb.bp_val[sb.n_entries - 1] - last_key;
            if (r < 65)
            begin
                k = next_key_above(last_key);
                v = $urandom();
            end
            else if (r < 78)
            begin
                // repeat the last delta
                k = next_key_above(last_key);
                v = k + last_delta;
            end
            else if (r < 90)
            begin
                k = (r < 84) ? last_key : $urandom_range(0, last_key);
                v = $urandom();
            end
            else
            begin
                k = $urandom();
                v = $urandom();
            end
        end
        send_item(OP_APPEND, k, v, pick_gap());
    endtask

    task automatic send_random_lookup();
        logic [31:0] k;
        int          r;
        int unsigned idx;
        r = $urandom_range(0, 99);
        if (sb.n_entries != 0 && r < 40)
        begin
            idx = $urandom_range(0, sb.n_entries - 1);
            k   = sb.bp_key[idx] + $urandom_range(0, 2) - 1;
        end
        else if (r < 85)
        begin
            k = $urandom();
        end
        else if (r < 92)
        begin
            k = 32'h0000_0000;
        end
        else
        begin
            k = 32'hFFFF_FFFF;
        end
        send_item(OP_LOOKUP, k, $urandom(), pick_gap());
    endtask

    initial
    begin
        sb          = new();
        burst_left  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_APPEND;
        key       <= '0;
        value     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, identity pairs, order and delta rules, wraparound
        send_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        send_item(OP_APPEND, 32'h0000_1234, 32'h0000_1234, 0);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
        send_item(OP_APPEND, 32'h0000_1000, 32'h0000_8000, 0);
        send_item(OP_LOOKUP, 32'h0000_0FFF, 32'h0, 0);
        send_item(OP_LOOKUP, 32'h0000_1000, 32'h0, 1);
        send_item(OP_APPEND, 32'h0000_1000, 32'h0000_0005, 0);
        send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0000, 0);
        send_item(OP_APPEND, 32'h0000_2000, 32'h0000_9000, 3);
        send_item(OP_APPEND, 32'h0000_2000, 32'h0000_0000, 0);
        send_item(OP_LOOKUP, 32'h0000_2005, 32'h0, 0);
        send_item(OP_LOOKUP, 32'h0000_1FFF, 32'h0, 0);
        send_item(OP_APPEND, 32'h0000_3000, 32'hFFFF_FFFF, 0);
        send_item(OP_LOOKUP, 32'h0000_3001, 32'h0, 5);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0);
        send_item(OP_APPEND, 32'h0000_3001, 32'hFFFF_FFFF, 0);
        send_item(OP_LOOKUP, 32'h0000_3000, 32'h0, 0);
        send_item(OP_LOOKUP, 32'h0000_3001, 32'h0, 0);
        drain_results();

        // grow the table to full, then keep hammering it with lookups and rejected appends
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if ($urandom_range(0, 99) < ((sb.n_entries < DEPTH) ? 60 : 15))
                send_random_append();
            else
                send_random_lookup();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results, %0d of them lookups; table holds %0d breakpoints.",
                 sb.results_seen, sb.lookups, sb.n_entries);
        $display("Appends stored %0d, skipped %0d, out of order %0d, rejected full %0d.",
                 sb.append_status[ST_OK], sb.append_status[ST_SKIP],
                 sb.append_status[ST_ORDER], sb.append_status[ST_FULL]);
        if (sb.errors == 0 && sb.pending_remaps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
